// File: hw/rtl/ldhc_pkg.sv
// Shared types and constants for the lockstep desync hash checker.
`timescale 1ns / 1ps
`default_nettype none

package ldhc_pkg;

    localparam int HISTORY_DEPTH = 64;
    localparam int SLOT_W        = $clog2(HISTORY_DEPTH);

    localparam logic [31:0] INVALID_FRAME = 32'hFFFF_FFFF;

    localparam logic OP_LOCAL  = 1'b0;
    localparam logic OP_REMOTE = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [31:0] frame_number;
        logic [31:0] hash_value;
    } req_t;

    typedef struct packed {
        logic        mismatch_now;
        logic        desync_seen;
        logic [31:0] desync_at_frame;
        logic        remote_waiting;
    } rsp_t;

    typedef struct packed {
        logic [31:0] frame;
        logic [31:0] hash;
    } entry_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        entry_t            entry;
    } tbl_wr_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } tbl_rd_t;

endpackage

`default_nettype wire

// File: hw/rtl/ldhc_table.sv
// Frame history table: one write and one registered read per cycle, with write bypass.
`timescale 1ns / 1ps
`default_nettype none

module ldhc_table (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      rd_en,
    input  wire logic [ldhc_pkg::SLOT_W-1:0] rd_slot,
    input  wire ldhc_pkg::tbl_wr_t         wr,
    output ldhc_pkg::tbl_rd_t              rd
);

    ldhc_pkg::entry_t                         hist_mem_reg [ldhc_pkg::HISTORY_DEPTH];
    logic [ldhc_pkg::HISTORY_DEPTH-1:0]       valid_reg;
    ldhc_pkg::entry_t                         rd_entry_reg;
    logic                                     rd_valid_reg;
    logic                                     bypass;

    // A read of the slot being written in the same cycle returns the new entry.
    assign bypass = wr.en && (wr.slot == rd_slot);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.slot] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= bypass ? 1'b1 : valid_reg[rd_slot];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            hist_mem_reg[wr.slot] <= wr.entry;
        end
        if (rd_en)
        begin
            rd_entry_reg <= bypass ? wr.entry : hist_mem_reg[rd_slot];
        end
    end

    assign rd.valid = rd_valid_reg;
    assign rd.entry = rd_entry_reg;

endmodule

`default_nettype wire

// File: hw/rtl/ldhc_check.sv
// Compare stage: request register, pending slot, desync status and result register.
`timescale 1ns / 1ps
`default_nettype none

module ldhc_check (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire ldhc_pkg::req_t    request,
    input  wire ldhc_pkg::tbl_rd_t rd,
    output ldhc_pkg::tbl_wr_t      wr,
    output logic                   done,
    output ldhc_pkg::rsp_t         result
);

    logic           s1_valid_reg;
    ldhc_pkg::req_t s1_req_reg;

    logic [31:0]    parked_frame_reg, parked_frame_next;
    logic [31:0]    parked_hash_reg,  parked_hash_next;
    logic [31:0]    mismatch_frame_reg, mismatch_frame_next;
    logic           mismatch_flag_reg,  mismatch_flag_next;
    logic           now;
    logic           frame_ok;
    logic           hit;

    logic           done_reg;
    ldhc_pkg::rsp_t result_reg;

    assign frame_ok = s1_valid_reg
                      && (s1_req_reg.frame_number != ldhc_pkg::INVALID_FRAME);
    assign hit      = rd.valid && (rd.entry.frame == s1_req_reg.frame_number);

    always_comb
    begin
        parked_frame_next   = parked_frame_reg;
        parked_hash_next    = parked_hash_reg;
        mismatch_frame_next = mismatch_frame_reg;
        mismatch_flag_next  = mismatch_flag_reg;
        now                 = 1'b0;
        wr.en               = 1'b0;
        wr.slot             = s1_req_reg.frame_number[ldhc_pkg::SLOT_W-1:0];
        wr.entry.frame      = s1_req_reg.frame_number;
        wr.entry.hash       = s1_req_reg.hash_value;
        if (frame_ok)
        begin
            unique case (s1_req_reg.opcode)
                ldhc_pkg::OP_LOCAL:
                begin
                    wr.en = 1'b1;
                    // A parked remote hash for this frame is settled now.
                    if (parked_frame_reg == s1_req_reg.frame_number)
                    begin
                        if (parked_hash_reg != s1_req_reg.hash_value)
                        begin
                            now = 1'b1;
                        end
                        parked_frame_next = ldhc_pkg::INVALID_FRAME;
                        parked_hash_next  = '0;
                    end
                end
                ldhc_pkg::OP_REMOTE:
                begin
                    if (!hit)
                    begin
                        parked_frame_next = s1_req_reg.frame_number;
                        parked_hash_next  = s1_req_reg.hash_value;
                    end
                    else if (rd.entry.hash != s1_req_reg.hash_value)
                    begin
                        now = 1'b1;
                    end
                end
                default:
                begin
                    wr.en = 1'b0;
                end
            endcase
            if (now)
            begin
                mismatch_frame_next = s1_req_reg.frame_number;
                mismatch_flag_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg       <= 1'b0;
            parked_frame_reg   <= ldhc_pkg::INVALID_FRAME;
            parked_hash_reg    <= '0;
            mismatch_frame_reg <= ldhc_pkg::INVALID_FRAME;
            mismatch_flag_reg  <= 1'b0;
            done_reg           <= 1'b0;
            result_reg         <= '0;
        end
        else
        begin
            s1_valid_reg       <= accept;
            parked_frame_reg   <= parked_frame_next;
            parked_hash_reg    <= parked_hash_next;
            mismatch_frame_reg <= mismatch_frame_next;
            mismatch_flag_reg  <= mismatch_flag_next;
            done_reg           <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                result_reg.mismatch_now    <= now;
                result_reg.desync_seen     <= mismatch_flag_next;
                result_reg.desync_at_frame <= mismatch_frame_next;
                result_reg.remote_waiting  <=
                    (parked_frame_next != ldhc_pkg::INVALID_FRAME);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg <= request;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// File: hw/rtl/lockstep_desync_hash_checker_core.sv
// Top level of the lockstep desync hash checker.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
// A request (opcode, frame_number, hash_value) is taken at a rising edge where
// start is high and busy is low. busy never rises, so one request can be given
// in every cycle. A local request stores the frame's hash in the history table;
// a remote request compares against it or parks in the single pending slot.
// Each request yields exactly one result after it is accepted: done is
// high for one cycle while result holds mismatch_now, desync_seen,
// desync_at_frame and remote_waiting as they stand after that request.
// The result passes the registered table read followed by the compare and
// result register; throughput is one request per cycle, with a bypass in the
// table so a read sees the write of the request just ahead.
// The receiver cannot stall; results must be taken when done is high.
// Reset clears the table's valid bits, the pending slot and the desync status
// at once; no clearing pass is needed.

module lockstep_desync_hash_checker_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire ldhc_pkg::req_t request,
    output logic                done,
    output ldhc_pkg::rsp_t      result
);

    logic              accept;
    ldhc_pkg::tbl_wr_t wr;
    ldhc_pkg::tbl_rd_t rd;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    ldhc_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_slot (request.frame_number[ldhc_pkg::SLOT_W-1:0]),
        .wr      (wr),
        .rd      (rd)
    );

    ldhc_check u_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .request (request),
        .rd      (rd),
        .wr      (wr),
        .done    (done),
        .result  (result)
    );

endmodule

`default_nettype wire

// File: hw/rtl/ldhc_checker.sv
// Port-level assertions for the lockstep desync hash checker and their bind.
`timescale 1ns / 1ps
`default_nettype none

module ldhc_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           start,
    input wire logic           busy,
    input wire logic           done,
    input wire ldhc_pkg::rsp_t result
);

    // Every accepted request produces its result.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##2 done)
        else $error("accepted request produced no result");

    // No result appears without an earlier accepted request.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result without a request");

    // The desync flag never falls once set.
    a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(result.desync_seen) |-> result.desync_seen)
        else $error("desync flag cleared");

    // A mismatch reported now is also recorded in the status.
    a_mismatch_recorded: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.mismatch_now |-> result.desync_seen
            && (result.desync_at_frame != ldhc_pkg::INVALID_FRAME))
        else $error("mismatch not recorded");

endmodule

bind lockstep_desync_hash_checker_core ldhc_checker u_ldhc_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .result  (result)
);

`default_nettype wire

// File: bench/tb_lockstep_desync_hash_checker_core.sv
// Self-checking testbench for the lockstep desync hash checker core.
`timescale 1ns / 1ps

module tb_lockstep_desync_hash_checker_core;

    import ldhc_pkg::*;

    typedef struct {
        req_t rq;
        bit   known;
        rsp_t want;
    } step_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t request;
    logic done;
    rsp_t result;

    // Expectation typed into the directed table travels alongside its request.
    bit   fixed_known;
    rsp_t fixed_want;

    // Predictor copy of the checker's state.
    logic [31:0] hist_frame [HISTORY_DEPTH];
    logic [31:0] hist_hash [HISTORY_DEPTH];
    bit          hist_valid [HISTORY_DEPTH];
    logic [31:0] park_frame;
    logic [31:0] park_hash;
    logic [31:0] desync_frame;
    bit          desync_flag;

    rsp_t  status_q[$];
    step_t directed_steps[$];

    logic [31:0] run_salt;
    int fail_count;
    int accepted;
    int checked;
    int mismatches;
    int parks;

    lockstep_desync_hash_checker_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("tb_lockstep_desync_hash_checker_core failed");
        $finish;
    end

    function automatic rsp_t apply_hash_item(req_t rq);
        rsp_t st;
        int   slot;
        st.mismatch_now = 1'b0;
        if (rq.frame_number != INVALID_FRAME)
        begin
            slot = rq.frame_number % HISTORY_DEPTH;
            if (rq.opcode == OP_LOCAL)
            begin
                hist_frame[slot] = rq.frame_number;
                hist_hash[slot]  = rq.hash_value;
                hist_valid[slot] = 1'b1;
                if (park_frame == rq.frame_number)
                begin
                    if (park_hash != rq.hash_value)
                    begin
                        desync_frame    = rq.frame_number;
                        desync_flag     = 1'b1;
                        st.mismatch_now = 1'b1;
                    end
                    park_frame = INVALID_FRAME;
                    park_hash  = '0;
                end
            end
            else if (!hist_valid[slot] || hist_frame[slot] != rq.frame_number)
            begin
                park_frame = rq.frame_number;
                park_hash  = rq.hash_value;
                parks++;
            end
            else if (hist_hash[slot] != rq.hash_value)
            begin
                desync_frame    = rq.frame_number;
                desync_flag     = 1'b1;
                st.mismatch_now = 1'b1;
            end
        end
        st.desync_seen     = desync_flag;
        st.desync_at_frame = desync_frame;
        st.remote_waiting  = (park_frame != INVALID_FRAME);
        return st;
    endfunction

    function automatic logic [31:0] true_hash(logic [31:0] f);
        return (f * 32'h9E37_79B1) ^ run_salt;
    endfunction

    task automatic add_row(input logic op, input logic [31:0] f, input logic [31:0] h,
                           input bit known, input logic now, input logic seen,
                           input logic [31:0] at_frame, input logic parked);
        step_t s;
        s.rq.opcode               = op;
        s.rq.frame_number         = f;
        s.rq.hash_value           = h;
        s.known                   = known;
        s.want.mismatch_now       = now;
        s.want.desync_seen        = seen;
        s.want.desync_at_frame    = at_frame;
        s.want.remote_waiting     = parked;
        directed_steps.push_back(s);
    endtask

    task automatic send_request(input req_t rq, input bit known, input rsp_t want);
        start       <= 1'b1;
        request     <= rq;
        fixed_known <= known;
        fixed_want  <= want;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic idle_gap(input int n);
        start       <= 1'b0;
        request     <= {1'($urandom_range(0, 1)), $urandom, $urandom};
        fixed_known <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Acceptance and result checking share one process so ordering within a step is fixed.
    always @(posedge clk)
    begin : monitor
        rsp_t want;
        rsp_t got;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                want = apply_hash_item(request);
                if (fixed_known)
                    want = fixed_want;
                status_q.push_back(want);
                accepted++;
                if (want.mismatch_now)
                    mismatches++;
            end
            if (done)
            begin
                got = result;
                if (status_q.size() == 0)
                begin
                    $error("result with no request outstanding: %h", got);
                    fail_count++;
                end
                else
                begin
                    want = status_q.pop_front();
                    checked++;
                    if (got.mismatch_now !== want.mismatch_now)
                    begin
                        $error("mismatch_now: expected %0b, got %0b",
                               want.mismatch_now, got.mismatch_now);
                        fail_count++;
                    end
                    if (got.desync_seen !== want.desync_seen)
                    begin
                        $error("desync_seen: expected %0b, got %0b",
                               want.desync_seen, got.desync_seen);
                        fail_count++;
                    end
                    if (got.desync_at_frame !== want.desync_at_frame)
                    begin
                        $error("desync_at_frame: expected %h, got %h",
                               want.desync_at_frame, got.desync_at_frame);
                        fail_count++;
                    end
                    if (got.remote_waiting !== want.remote_waiting)
                    begin
                        $error("remote_waiting: expected %0b, got %0b",
                               want.remote_waiting, got.remote_waiting);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial
    begin : stimulus
        req_t        rq;
        rsp_t        blank;
        logic [31:0] lead_frame;
        logic [31:0] f;
        logic [31:0] h;
        int          pick;
        int          drain;

        rst_n       <= 1'b0;
        start       <= 1'b0;
        request     <= '0;
        fixed_known <= 1'b0;
        fixed_want  <= '0;
        blank        = '0;
        fail_count   = 0;
        accepted     = 0;
        checked      = 0;
        mismatches   = 0;
        parks        = 0;
        run_salt     = $urandom;
        lead_frame   = $urandom;
        foreach (hist_valid[i])
        begin
            hist_valid[i] = 1'b0;
            hist_frame[i] = '0;
            hist_hash[i]  = '0;
        end
        park_frame   = INVALID_FRAME;
        park_hash    = '0;
        desync_frame = INVALID_FRAME;
        desync_flag  = 1'b0;

        // Invalid frames, slot aliasing, replacement of the pending slot, a remote
        // hash that finds its entry while another is parked, and mismatches both ways.
        add_row(OP_REMOTE, INVALID_FRAME, 32'h0, 1, 0, 0, INVALID_FRAME, 0);
        add_row(OP_LOCAL,  32'h0, 32'h0, 1, 0, 0, INVALID_FRAME, 0);
        add_row(OP_REMOTE, 32'h0, 32'h0, 1, 0, 0, INVALID_FRAME, 0);
        add_row(OP_REMOTE, 32'h0, 32'hFFFF_FFFF, 1, 1, 1, 32'h0, 0);
        add_row(OP_LOCAL,  32'hFFFF_FFFE, 32'hFFFF_FFFF, 1, 0, 1, 32'h0, 0);
        add_row(OP_REMOTE, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1, 0, 1, 32'h0, 0);
        add_row(OP_REMOTE, 32'h40, 32'h5, 1, 0, 1, 32'h0, 1);
        add_row(OP_REMOTE, 32'h80, 32'h6, 1, 0, 1, 32'h0, 1);
        add_row(OP_LOCAL,  32'h40, 32'h5, 1, 0, 1, 32'h0, 1);
        add_row(OP_LOCAL,  32'h80, 32'h7, 1, 1, 1, 32'h80, 0);
        add_row(OP_REMOTE, 32'h80, 32'h7, 1, 0, 1, 32'h80, 0);
        add_row(OP_REMOTE, 32'h5, 32'hA5A5_A5A5, 1, 0, 1, 32'h80, 1);
        add_row(OP_LOCAL,  INVALID_FRAME, 32'h1234, 1, 0, 1, 32'h80, 1);
        add_row(OP_REMOTE, INVALID_FRAME, 32'h0, 1, 0, 1, 32'h80, 1);
        add_row(OP_LOCAL,  32'h5, 32'hA5A5_A5A5, 1, 0, 1, 32'h80, 0);
        add_row(OP_REMOTE, 32'h45, 32'h1, 1, 0, 1, 32'h80, 1);
        add_row(OP_REMOTE, 32'h5, 32'hA5A5_A5A5, 1, 0, 1, 32'h80, 1);
        add_row(OP_REMOTE, 32'h5, 32'h0, 1, 1, 1, 32'h5, 1);
        add_row(OP_LOCAL,  32'h45, 32'h1, 1, 0, 1, 32'h5, 0);
        add_row(OP_LOCAL,  32'hFFFF_FFC0, 32'h1234_5678, 0, 0, 0, '0, 0);
        add_row(OP_REMOTE, 32'hFFFF_FFC0, 32'h1234_5678, 0, 0, 0, '0, 0);
        add_row(OP_REMOTE, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, '0, 0);
        add_row(OP_LOCAL,  32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, '0, 0);
        add_row(OP_LOCAL,  32'h7FFF_FFFF, 32'h8000_0001, 0, 0, 0, '0, 0);
        add_row(OP_REMOTE, 32'h7FFF_FFFF, 32'h8000_0001, 0, 0, 0, '0, 0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_steps[i])
            send_request(directed_steps[i].rq, directed_steps[i].known,
                         directed_steps[i].want);

        // Both peers mostly walk a shared window of frames with agreeing hashes;
        // the rest are aliased slots, wild frames, invalid frames and corrupt hashes.
        for (int i = 0; i < 1600; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                f = lead_frame + $urandom_range(0, 5);
            else if (pick < 80)
                f = lead_frame + HISTORY_DEPTH * $urandom_range(1, 3) + $urandom_range(0, 5);
            else if (pick < 90)
                f = $urandom;
            else if (pick < 95)
                f = INVALID_FRAME;
            else
                f = INVALID_FRAME - $urandom_range(1, 8);
            if ($urandom_range(0, 3) == 0)
                lead_frame = lead_frame + 1;

            pick = $urandom_range(0, 99);
            if (pick < 85)
                h = true_hash(f);
            else if (pick < 93)
                h = true_hash(f) ^ (32'h1 << $urandom_range(0, 31));
            else
                h = $urandom;

            rq.opcode       = $urandom_range(0, 1) ? OP_REMOTE : OP_LOCAL;
            rq.frame_number = f;
            rq.hash_value   = h;

            if (i < 1300 && ((i / 100) % 3) != 2 && $urandom_range(0, 3) == 0)
                idle_gap($urandom_range(1, 12));
            send_request(rq, 1'b0, blank);
        end

        start       <= 1'b0;
        fixed_known <= 1'b0;
        drain = 0;
        while (status_q.size() != 0 && drain < 100)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (4) @(posedge clk);
        if (status_q.size() != 0)
        begin
            $error("%0d results never arrived", status_q.size());
            fail_count++;
        end

        $display("Sent %0d requests and checked %0d results, covering %0d predicted",
                 accepted, checked, mismatches);
        $display("hash mismatches and %0d remote hashes parked ahead of their local hash.",
                 parks);
        if (fail_count == 0)
            $display("tb_lockstep_desync_hash_checker_core passed");
        else
            $display("tb_lockstep_desync_hash_checker_core failed");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/ldhc_pkg.sv
hw/rtl/ldhc_table.sv
hw/rtl/ldhc_check.sv
hw/rtl/lockstep_desync_hash_checker_core.sv
hw/rtl/ldhc_checker.sv
bench/tb_lockstep_desync_hash_checker_core.sv
